[hw/rtl/lpi_pkg.sv]
// lpi_pkg: shared types, constants and coefficient tables of the propagator integrand
`timescale 1ns / 1ps
package lpi_pkg;

    // field widths
    localparam int COORD_W    = 24;
    localparam int DISP_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int VALUE_W    = 48;
    localparam int TRIG_W     = 31;   // Q1.30, at most 1.0
    localparam int SQ_W       = 61;   // Q.60 square of a trig value
    localparam int DEN_W      = 63;   // sum of four squares
    localparam int QUOT_BITS  = 48;
    localparam int HORNER_N   = 7;

    // pipeline depths
    localparam int TRIG_LAT   = 2 + 3 * HORNER_N + 1;
    localparam int DIV_LAT    = QUOT_BITS + 2;
    localparam int PHASE_LAT  = 2;
    localparam int MERGE_LAT  = 1;
    localparam int PIPE_LAT   = PHASE_LAT + TRIG_LAT + MERGE_LAT + DIV_LAT;

    // fixed-point constants
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [29:0] HALF_Q30   = 30'h2000_0000;
    localparam logic [31:0] HALFPI_Q31 = 32'hC90F_DAA2;
    localparam logic [VALUE_W-1:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] NEG_LIMIT = 48'h8000_0000_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISP_X = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_Y = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_Z = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISP_T = 8'd3;

    // quadrant codes of the phase
    localparam logic [1:0] QUAD_NEG_SIN = 2'd1;
    localparam logic [1:0] QUAD_NEG_COS = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
        logic [COORD_W-1:0] coord_t;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
        logic                      zero_denominator;
    } t_out;

    // horner divisor for one step of the sine or cosine series
    function automatic logic [7:0] horner_k(input logic want_cos, input logic [2:0] step);
        logic [7:0] k;
        unique case ({want_cos, step})
            4'b0000: k = 8'd210;
            4'b0001: k = 8'd156;
            4'b0010: k = 8'd110;
            4'b0011: k = 8'd72;
            4'b0100: k = 8'd42;
            4'b0101: k = 8'd20;
            4'b0110: k = 8'd6;
            4'b1000: k = 8'd182;
            4'b1001: k = 8'd132;
            4'b1010: k = 8'd90;
            4'b1011: k = 8'd56;
            4'b1100: k = 8'd30;
            4'b1101: k = 8'd12;
            4'b1110: k = 8'd2;
            default: k = 8'd2;
        endcase
        return k;
    endfunction

    // floor(2^32 / k) for the same divisors
    function automatic logic [31:0] horner_recip(input logic want_cos, input logic [2:0] step);
        logic [31:0] m;
        unique case ({want_cos, step})
            4'b0000: m = 32'd20452225;
            4'b0001: m = 32'd27531841;
            4'b0010: m = 32'd39045157;
            4'b0011: m = 32'd59652323;
            4'b0100: m = 32'd102261126;
            4'b0101: m = 32'd214748364;
            4'b0110: m = 32'd715827882;
            4'b1000: m = 32'd23598721;
            4'b1001: m = 32'd32537631;
            4'b1010: m = 32'd47721858;
            4'b1011: m = 32'd76695844;
            4'b1100: m = 32'd143165576;
            4'b1101: m = 32'd357913941;
            4'b1110: m = 32'd2147483648;
            default: m = 32'd2147483648;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/lattice_propagator_integrand.sv]
// lattice_propagator_integrand: top level, phase lane, four sine-square lanes, merge, divider
//
// Computes cos(2*pi*(n.p)) / sum(sin^2(pi*p_i)) for one four-dimensional point p per
// transaction, n being the integer displacement held in four configuration registers.
// Input channel: i_in_valid / o_in_stall with the point in i_in_data.
// Output channel: o_out_valid / i_out_stall with value, saturated and zero_denominator.
// A transaction moves at a clock edge where valid is high and stall is low.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0..3 selects
// disp_x..disp_t; other indexes are dropped. Write only while the block is idle.
// Throughput: one point per cycle while o_in_stall is low. A point passes through
// 77 pipeline stages, the first loaded at the accepting edge (phase 2, trig lanes
// 24, merge 1, divider 50), and then the output register that drives o_out_valid;
// the divider's 48 one-bit stages dominate the depth.
// When the receiver stalls, the result waits in the output register and one more
// finished result is caught by a skid register; only when the skid is full does
// the whole pipeline freeze and o_in_stall rise.
// Reset clears the displacement registers, every valid bit and the skid; the block
// accepts a point in the first cycle after reset.
`timescale 1ns / 1ps
module lattice_propagator_integrand #(
    parameter int COORD_FRAC_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  lpi_pkg::t_in                      i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output lpi_pkg::t_out                     o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lpi_pkg::DISP_W-1:0]        i_cfg_data
);

    localparam int F  = COORD_FRAC_BITS;
    localparam int PL = lpi_pkg::PIPE_LAT;
    localparam int TL = lpi_pkg::TRIG_LAT;

    // displacement registers
    logic signed [lpi_pkg::DISP_W-1:0] r_disp [4];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_disp[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lpi_pkg::REG_DISP_X: r_disp[0] <= i_cfg_data;
                lpi_pkg::REG_DISP_Y: r_disp[1] <= i_cfg_data;
                lpi_pkg::REG_DISP_Z: r_disp[2] <= i_cfg_data;
                lpi_pkg::REG_DISP_T: r_disp[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance and valid line
    logic          en;
    logic [PL-1:0] r_vld;
    logic          r_out_valid;
    logic          r_skid_valid;

    assign en         = !r_skid_valid;
    assign o_in_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PL-2:0], i_in_valid};
        end
    end

    // coordinates taken to F fraction bits
    logic [F-1:0] coord [4];
    assign coord[0] = F'(i_in_data.coord_x);
    assign coord[1] = F'(i_in_data.coord_y);
    assign coord[2] = F'(i_in_data.coord_z);
    assign coord[3] = F'(i_in_data.coord_t);

    // phase lane: n.p modulo one
    logic [F-1:0] r_prod [4];
    logic [F-1:0] r_phase;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_prod[i] <= F'(F'(r_disp[i]) * coord[i]);
            end
            r_phase <= r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];
        end
    end

    // numerator trig lane
    logic [31:0] num_angle;
    logic [30:0] num_trig;
    logic [1:0]  r_quad_d [TL];

    assign num_angle = {r_phase[F-3:0], {(34-F){1'b0}}};

    lpi_trig u_num_trig (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_angle    (num_angle),
        .i_want_cos (!r_phase[F-2]),
        .o_result   (num_trig)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quad_d[0] <= r_phase[F-1:F-2];
            for (int i = 1; i < TL; i++) begin
                r_quad_d[i] <= r_quad_d[i-1];
            end
        end
    end

    // four sine-square lanes
    logic [30:0]                 den_trig [4];
    logic [lpi_pkg::SQ_W-1:0]    r_sq     [4];

    genvar gl;
    generate
        for (gl = 0; gl < 4; gl++) begin : g_lane
            logic [31:0] angle;
            assign angle = 32'({coord[gl][F-2:0], {(33-F){1'b0}}});
            lpi_trig u_trig (
                .i_clk      (i_clk),
                .i_en       (en),
                .i_angle    (angle),
                .i_want_cos (coord[gl][F-1]),
                .o_result   (den_trig[gl])
            );
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_sq[gl] <= lpi_pkg::SQ_W'(62'(den_trig[gl]) * 62'(den_trig[gl]));
                end
            end
        end
    endgenerate

    // merge: sum of the four squares over two adder levels, numerator held alongside
    logic [lpi_pkg::DEN_W-1:0] r_pair [2];
    logic [lpi_pkg::DEN_W-1:0] r_den;
    logic [30:0]               r_num;
    logic [1:0]                r_quad;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pair[0] <= lpi_pkg::DEN_W'(r_sq[0]) + lpi_pkg::DEN_W'(r_sq[1]);
            r_pair[1] <= lpi_pkg::DEN_W'(r_sq[2]) + lpi_pkg::DEN_W'(r_sq[3]);
            r_den     <= r_pair[0] + r_pair[1];
            r_num     <= num_trig;
            r_quad    <= r_quad_d[TL-1];
        end
    end

    // divider
    lpi_pkg::t_out div_res;

    lpi_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (r_num),
        .i_den  (r_den),
        .i_quad (r_quad),
        .o_res  (div_res)
    );

    // output register with skid
    lpi_pkg::t_out r_out_data;
    lpi_pkg::t_out r_skid_data;
    logic          inc_valid;

    assign inc_valid = en && r_vld[PL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= inc_valid;
            end
        end else if (inc_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_out_stall) begin
            r_out_data <= r_skid_valid ? r_skid_data : div_res;
        end else if (inc_valid) begin
            r_skid_data <= div_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid) else $error("skid holds data with empty output");

    a_skid_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !en) else $error("pipeline advances while skid is full");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> !r_skid_valid) else $error("skid failed to drain");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data.saturated && r_out_data.zero_denominator))
        else $error("saturated and zero denominator both set");

endmodule

[hw/rtl/lpi_trig.sv]
// lpi_trig: pipelined quarter-turn sine/cosine lane, horner series with constant divides
`timescale 1ns / 1ps
module lpi_trig (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_angle,
    input  logic        i_want_cos,
    output logic [30:0] o_result
);

    localparam int N = lpi_pkg::HORNER_N;

    // angle to radians, then square
    logic [30:0] r_t1;
    logic        r_c1;
    logic [30:0] r_t2s_t;
    logic [31:0] r_t2s_t2;
    logic        r_t2s_c;
    logic [63:0] n_tprod;
    logic [61:0] n_tsq;

    assign n_tprod = 64'(i_angle) * 64'(lpi_pkg::HALFPI_Q31) + 64'h1_0000_0000;
    assign n_tsq   = 62'(r_t1) * 62'(r_t1) + 62'(lpi_pkg::HALF_Q30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1     <= 31'(n_tprod >> 33);
            r_c1     <= i_want_cos;
            r_t2s_t  <= r_t1;
            r_t2s_t2 <= 32'(n_tsq >> 30);
            r_t2s_c  <= r_c1;
        end
    end

    // per-step stage registers
    logic [31:0] r_a_m  [N];
    logic [30:0] r_a_t  [N];
    logic [31:0] r_a_t2 [N];
    logic        r_a_c  [N];
    logic [32:0] r_b_x  [N];
    logic [31:0] r_b_qe [N];
    logic [30:0] r_b_t  [N];
    logic [31:0] r_b_t2 [N];
    logic        r_b_c  [N];
    logic [30:0] r_h    [N];
    logic [30:0] r_c_t  [N];
    logic [31:0] r_c_t2 [N];
    logic        r_c_c  [N];

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_step
            logic [30:0] h_src;
            logic [30:0] t_src;
            logic [31:0] t2_src;
            logic        c_src;
            logic [62:0] n_hprod;
            logic [7:0]  k_a;
            logic [31:0] m_a;
            logic [32:0] n_x;
            logic [64:0] n_rprod;
            logic [7:0]  k_c;
            logic [39:0] n_qk;
            logic [39:0] n_rem;
            logic [33:0] n_q;
            logic [30:0] n_h;

            if (gi == 0) begin : g_first
                assign h_src  = lpi_pkg::ONE_Q30;
                assign t_src  = r_t2s_t;
                assign t2_src = r_t2s_t2;
                assign c_src  = r_t2s_c;
            end else begin : g_next
                assign h_src  = r_h[gi-1];
                assign t_src  = r_c_t[gi-1];
                assign t2_src = r_c_t2[gi-1];
                assign c_src  = r_c_c[gi-1];
            end

            // t2 * h, rounded back to Q.30
            assign n_hprod = 63'(t2_src) * 63'(h_src) + 63'(lpi_pkg::HALF_Q30);

            // rounded divide by the step constant via reciprocal
            assign k_a     = lpi_pkg::horner_k(r_a_c[gi], 3'(gi));
            assign m_a     = lpi_pkg::horner_recip(r_a_c[gi], 3'(gi));
            assign n_x     = 33'(r_a_m[gi]) + 33'(k_a >> 1);
            assign n_rprod = 65'(n_x) * 65'(m_a);

            // estimate falls short by at most two
            assign k_c   = lpi_pkg::horner_k(r_b_c[gi], 3'(gi));
            assign n_qk  = 40'(r_b_qe[gi]) * 40'(k_c);
            assign n_rem = 40'(r_b_x[gi]) - n_qk;
            assign n_q   = 34'(r_b_qe[gi]) + 34'(n_rem >= 40'(k_c))
                         + 34'(n_rem >= 40'({k_c, 1'b0}));
            assign n_h   = (n_q > 34'(lpi_pkg::ONE_Q30)) ? 31'd0
                         : 31'(34'(lpi_pkg::ONE_Q30) - n_q);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a_m[gi]  <= 32'(n_hprod >> 30);
                    r_a_t[gi]  <= t_src;
                    r_a_t2[gi] <= t2_src;
                    r_a_c[gi]  <= c_src;
                    r_b_x[gi]  <= n_x;
                    r_b_qe[gi] <= 32'(n_rprod >> 32);
                    r_b_t[gi]  <= r_a_t[gi];
                    r_b_t2[gi] <= r_a_t2[gi];
                    r_b_c[gi]  <= r_a_c[gi];
                    r_h[gi]    <= n_h;
                    r_c_t[gi]  <= r_b_t[gi];
                    r_c_t2[gi] <= r_b_t2[gi];
                    r_c_c[gi]  <= r_b_c[gi];
                end
            end
        end
    endgenerate

    // sine takes a final multiply by t; clamp to one
    logic [61:0] n_sin;
    logic [30:0] n_res;
    logic [30:0] r_res;

    assign n_sin = 62'(r_c_t[N-1]) * 62'(r_h[N-1]) + 62'(lpi_pkg::HALF_Q30);

    always_comb begin
        if (r_c_c[N-1]) begin
            n_res = r_h[N-1];
        end else if ((n_sin >> 30) > 62'(lpi_pkg::ONE_Q30)) begin
            n_res = lpi_pkg::ONE_Q30;
        end else begin
            n_res = 31'(n_sin >> 30);
        end
        if (n_res > lpi_pkg::ONE_Q30) begin
            n_res = lpi_pkg::ONE_Q30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule

[hw/rtl/lpi_div.sv]
// lpi_div: pipelined restoring divider, rounding, saturation and sign of the result
`timescale 1ns / 1ps
module lpi_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [30:0]               i_num,
    input  logic [lpi_pkg::DEN_W-1:0] i_den,
    input  logic [1:0]                i_quad,
    output lpi_pkg::t_out             o_res
);

    localparam int QB = lpi_pkg::QUOT_BITS;
    localparam int DW = lpi_pkg::DEN_W;

    // setup: quotient reaches 2^48 exactly when num * 64 >= den
    logic [DW:0]   n_nshift;
    logic          n_big;
    logic [DW-1:0] r_den  [QB+1];
    logic [DW-1:0] r_rem  [QB+1];
    logic [QB-1:0] r_q    [QB+1];
    logic          r_big  [QB+1];
    logic          r_zero [QB+1];
    logic          r_neg  [QB+1];
    logic          r_nz   [QB+1];

    assign n_nshift = (DW+1)'({i_num, 6'b0});
    assign n_big    = n_nshift >= (DW+1)'(i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_rem[0]  <= n_big ? '0 : DW'(n_nshift);
            r_q[0]    <= '0;
            r_big[0]  <= n_big;
            r_zero[0] <= (i_den == '0);
            r_nz[0]   <= (i_num != '0);
            r_neg[0]  <= ((i_quad == lpi_pkg::QUAD_NEG_SIN) || (i_quad == lpi_pkg::QUAD_NEG_COS))
                         && (i_num != '0);
        end
    end

    // one quotient bit per stage
    genvar gj;
    generate
        for (gj = 0; gj < QB; gj++) begin : g_bit
            logic [DW:0] n_r2;
            logic        n_ge;
            assign n_r2 = {r_rem[gj], 1'b0};
            assign n_ge = n_r2 >= (DW+1)'(r_den[gj]);
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[gj+1]  <= DW'(n_ge ? (n_r2 - (DW+1)'(r_den[gj])) : n_r2);
                    r_q[gj+1]    <= {r_q[gj][QB-2:0], n_ge};
                    r_den[gj+1]  <= r_den[gj];
                    r_big[gj+1]  <= r_big[gj];
                    r_zero[gj+1] <= r_zero[gj];
                    r_neg[gj+1]  <= r_neg[gj];
                    r_nz[gj+1]   <= r_nz[gj];
                end
            end
        end
    endgenerate

    // rounding, clamping and sign
    logic                       n_rnd;
    logic [QB:0]                n_mag;
    logic [lpi_pkg::VALUE_W-1:0] n_limit;
    logic [lpi_pkg::VALUE_W-1:0] n_sel;
    lpi_pkg::t_out              n_res;
    lpi_pkg::t_out              r_res;

    assign n_rnd   = {r_rem[QB], 1'b0} >= (DW+1)'(r_den[QB]);
    assign n_mag   = (QB+1)'(r_q[QB]) + (QB+1)'(n_rnd);
    assign n_limit = r_neg[QB] ? lpi_pkg::NEG_LIMIT : lpi_pkg::POS_LIMIT;

    always_comb begin
        n_res = '0;
        if (r_zero[QB]) begin
            n_sel                  = r_nz[QB] ? n_limit : '0;
            n_res.zero_denominator = 1'b1;
        end else if (r_big[QB] || (n_mag > (QB+1)'(n_limit))) begin
            n_sel           = n_limit;
            n_res.saturated = 1'b1;
        end else begin
            n_sel = n_mag[QB-1:0];
        end
        n_res.value = r_neg[QB] ? -$signed(n_sel) : $signed(n_sel);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[test/lattice_propagator_integrand_tb.sv]
// lattice_propagator_integrand_tb: self-checking bench with a bit-exact integrand predictor
`timescale 1ns / 1ps
module lattice_propagator_integrand_tb;

    localparam int FRAC = 24;
    localparam int DRAIN_CYCLES = lpi_pkg::PIPE_LAT + 20;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_stall;
    lpi_pkg::t_in i_in_data;
    logic         o_out_valid;
    logic         i_out_stall;
    lpi_pkg::t_out o_out_data;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [lpi_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [lpi_pkg::DISP_W-1:0]    i_cfg_data;

    // directed stimulus row; chk marks rows whose result is typed in
    typedef struct {
        logic [7:0]    disp [4];
        lpi_pkg::t_in  pt;
        bit            chk;
        lpi_pkg::t_out res;
    } t_dir_row;

    logic signed [7:0] disp_q [4];
    lpi_pkg::t_out integrand_q [$];
    lpi_pkg::t_out typed_q [$];
    bit      typed_flag_q [$];
    t_dir_row dir_rows [$];
    int      fail_cnt;
    int      result_cnt;
    int      sat_cnt;
    int      zden_cnt;
    bit      no_idle;

    lattice_propagator_integrand #(.COORD_FRAC_BITS(FRAC)) dut (.*);

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // horner series of sine or cosine, Q1.30
    function automatic longint unsigned series(longint unsigned t2, bit want_cos);
        longint unsigned sin_k [7] = '{210, 156, 110, 72, 42, 20, 6};
        longint unsigned cos_k [7] = '{182, 132, 90, 56, 30, 12, 2};
        longint unsigned h, m, s, k;
        h = 64'd1 << 30;
        for (int i = 0; i < 7; i++) begin
            k = want_cos ? cos_k[i] : sin_k[i];
            m = (t2 * h + (64'd1 << 29)) >> 30;
            s = (m + k / 2) / k;
            h = (s > (64'd1 << 30)) ? 64'd0 : (64'd1 << 30) - s;
        end
        return h;
    endfunction

    // sine or cosine of a Q0.32 fraction of a quarter turn
    function automatic longint unsigned quarter_wave(logic [31:0] a, bit want_cos);
        longint unsigned t, t2, r;
        t  = (longint'(a) * longint'(lpi_pkg::HALFPI_Q31) + (64'd1 << 32)) >> 33;
        t2 = (t * t + (64'd1 << 29)) >> 30;
        if (want_cos) r = series(t2, 1'b1);
        else r = (t * series(t2, 1'b0) + (64'd1 << 29)) >> 30;
        return (r > (64'd1 << 30)) ? (64'd1 << 30) : r;
    endfunction

    // cos(2 pi n.p) / sum sin^2(pi p_i) in Q23.24 with clamping
    function automatic lpi_pkg::t_out integrand(lpi_pkg::t_in p);
        logic [23:0] c [4];
        longint signed acc;
        logic [23:0] phase;
        longint unsigned nm, den, s, q, r, mag, limit;
        bit neg, big;
        lpi_pkg::t_out o;
        c[0] = p.coord_x; c[1] = p.coord_y; c[2] = p.coord_z; c[3] = p.coord_t;
        acc = 0;
        den = 0;
        big = 0;
        for (int i = 0; i < 4; i++) begin
            acc += longint'(disp_q[i]) * longint'({40'd0, c[i]});
            s = quarter_wave({c[i][22:0], 9'd0}, c[i][23]);
            den += s * s;
        end
        phase = acc[23:0];
        nm = quarter_wave({phase[21:0], 10'd0}, phase[22] == 1'b0);
        neg = (phase[23:22] == lpi_pkg::QUAD_NEG_SIN || phase[23:22] == lpi_pkg::QUAD_NEG_COS)
              && nm != 0;
        limit = neg ? 64'(lpi_pkg::NEG_LIMIT) : 64'(lpi_pkg::POS_LIMIT);
        o.saturated = 1'b0;
        o.zero_denominator = 1'b0;
        if (den == 0) begin
            mag = (nm == 0) ? 64'd0 : limit;
            o.zero_denominator = 1'b1;
        end else begin
            q = nm / den;
            r = nm % den;
            for (int i = 0; i < 54 && !big; i++) begin
                r = r << 1;
                q = q << 1;
                if (r >= den) begin
                    r -= den;
                    q |= 64'd1;
                end
                if (q >= (64'd1 << 48)) big = 1;
            end
            if (!big && 2 * r >= den) q++;
            if (big || q > limit) begin
                mag = limit;
                o.saturated = 1'b1;
            end else begin
                mag = q;
            end
        end
        o.value = neg ? 48'(-mag) : 48'(mag);
        return o;
    endfunction

    // one register write transaction; the caller drops valid after the last one
    task automatic write_reg(logic [lpi_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= lpi_pkg::REG_DISP_T) disp_q[idx] = data;
    endtask

    // stop sending, let every expected result come out, then the pipeline drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (integrand_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_disp(logic [7:0] dx, logic [7:0] dy, logic [7:0] dz, logic [7:0] dt);
        wait_idle();
        write_reg(lpi_pkg::REG_DISP_X, dx);
        write_reg(lpi_pkg::REG_DISP_Y, dy);
        write_reg(lpi_pkg::REG_DISP_Z, dz);
        write_reg(lpi_pkg::REG_DISP_T, dt);
        i_cfg_valid <= 1'b0;
    endtask

    // one input transaction, with an optional idle burst after it
    task automatic send_point(lpi_pkg::t_in p, bit chk, lpi_pkg::t_out res);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (o_in_stall);
        integrand_q.push_back(integrand(p));
        typed_flag_q.push_back(chk);
        typed_q.push_back(res);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'($urandom_range(0, 3));
            1: return 24'hFFFFFF - 24'($urandom_range(0, 3));
            2: return 24'h800000 ^ 24'($urandom_range(0, 15));
            3: return 24'($urandom_range(0, 4095));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void add_row(logic [7:0] dx, logic [7:0] dy, logic [7:0] dz,
                                    logic [7:0] dt, logic [23:0] cx, logic [23:0] cy,
                                    logic [23:0] cz, logic [23:0] ct, bit chk,
                                    logic [47:0] val, bit sat, bit zd);
        t_dir_row row;
        row.disp = '{dx, dy, dz, dt};
        row.pt = '{coord_x: cx, coord_y: cy, coord_z: cz, coord_t: ct};
        row.chk = chk;
        row.res = '{value: val, saturated: sat, zero_denominator: zd};
        dir_rows.push_back(row);
    endfunction

    // stimulus
    initial begin
        lpi_pkg::t_in p;
        lpi_pkg::t_out none;
        logic [7:0] cur [4];
        none = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        disp_q = '{0, 0, 0, 0};
        cur = '{0, 0, 0, 0};
        fail_cnt = 0; result_cnt = 0; sat_cnt = 0; zden_cnt = 0;
        no_idle = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: reset displacement first, then extremes
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 1, lpi_pkg::POS_LIMIT, 0, 1);
        add_row(0, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000, 24'h800000,
                1, 48'h400000, 0, 0);
        add_row(0, 0, 0, 0, 1, 0, 0, 0, 1, lpi_pkg::POS_LIMIT, 1, 0);
        add_row(0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 24'h400000, 24'hC00000, 24'h7FFFFF, 24'h000001, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 24'h400000, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 24'hC00000, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 24'h600000, 1, 0, 0, 0, 0, 0, 0);
        add_row(1, 1, 1, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, 0);
        add_row(8'h80, 8'h7F, 8'h80, 8'h7F, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                24'hFFFFFF, 0, 0, 0, 0);
        add_row(8'h80, 8'h7F, 8'h80, 8'h7F, 24'h123456, 24'hABCDEF, 24'h000001,
                24'hFFFFFE, 0, 0, 0, 0);
        add_row(8'h7F, 8'h7F, 8'h7F, 8'h7F, 24'h555555, 24'hAAAAAA, 24'h0F0F0F,
                24'hF0F0F0, 0, 0, 0, 0);
        add_row(8'h80, 8'h80, 8'h80, 8'h80, 24'h400000, 24'h400000, 24'h400000,
                24'h400000, 0, 0, 0, 0);
        add_row(8'hFF, 2, 8'hFE, 3, 24'h200000, 24'h000002, 24'hE00000, 24'h7FFFFF,
                0, 0, 0, 0);
        add_row(8'hFF, 2, 8'hFE, 3, 0, 0, 0, 1, 0, 0, 0, 0);
        foreach (dir_rows[i]) begin
            if (dir_rows[i].disp != cur) begin
                cur = dir_rows[i].disp;
                set_disp(cur[0], cur[1], cur[2], cur[3]);
            end
            send_point(dir_rows[i].pt, dir_rows[i].chk, dir_rows[i].res);
        end

        // an index past the register file is dropped
        wait_idle();
        write_reg(8'd4, 8'h55);
        write_reg(8'hFF, 8'hAA);
        i_cfg_valid <= 1'b0;

        // random part over several displacement settings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_disp(8'h7F, 8'h7F, 8'h7F, 8'h7F);
                1: set_disp(8'h80, 8'h80, 8'h80, 8'h80);
                2: set_disp(0, 0, 0, 0);
                3: set_disp(8'h80, 8'h7F, 0, 8'hFF);
                default: set_disp(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (ph == 7) no_idle = 1;
            for (int n = 0; n < 180; n++) begin
                p.coord_x = rand_coord();
                p.coord_y = rand_coord();
                p.coord_z = rand_coord();
                p.coord_t = rand_coord();
                send_point(p, 0, none);
            end
        end

        wait_idle();
        $display("covered %0d points over directed and random displacement settings",
                 result_cnt);
        $display("%0d clamped on overflow, %0d with zero denominator", sat_cnt, zden_cnt);
        if (fail_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver stall bursts
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        lpi_pkg::t_out exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (integrand_q.size() == 0) begin
                $error("result transaction with nothing expected");
                fail_cnt++;
            end else begin
                exp_r = integrand_q.pop_front();
                if (typed_flag_q.pop_front()) exp_r = typed_q.pop_front();
                else void'(typed_q.pop_front());
                result_cnt++;
                sat_cnt += o_out_data.saturated;
                zden_cnt += o_out_data.zero_denominator;
                if (o_out_data.value !== exp_r.value) begin
                    $error("value: expected %0d, got %0d", exp_r.value, o_out_data.value);
                    fail_cnt++;
                end
                if (o_out_data.saturated !== exp_r.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           exp_r.saturated, o_out_data.saturated);
                    fail_cnt++;
                end
                if (o_out_data.zero_denominator !== exp_r.zero_denominator) begin
                    $error("zero_denominator: expected %0b, got %0b",
                           exp_r.zero_denominator, o_out_data.zero_denominator);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
